// ===== rtl/prrm_pkg.sv =====
package prrm_pkg;

	localparam int IN_FRAC_DEF = 16;
	localparam int OUT_FRAC_DEF = 30;
	localparam int CORDIC_STEPS = 30;
	localparam int RAD_PHASE_SHIFT = 2;
	localparam int DEG_PHASE_SHIFT = 8;

	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic [31:0] RAD_PHASE_MUL = 32'd2734261102;
	localparam logic [31:0] DEG_PHASE_MUL = 32'd3054198966;

	localparam logic [1:0] ROW_LAST = 2'd2;

	typedef enum logic [2:0] {
		FMT_QUAT_XYZW = 3'd0,
		FMT_QUAT_WXYZ = 3'd1,
		FMT_RPY_RAD   = 3'd2,
		FMT_RPY_DEG   = 3'd3,
		FMT_YPR_RAD   = 3'd4,
		FMT_YPR_DEG   = 3'd5
	} pose_fmt_t;

	typedef logic signed [33:0] q30_t;
	typedef logic [8:0][31:0] mat_t;

	function automatic logic [31:0] atan_phase(int i);
		logic [31:0] v;
		unique case (i)
			0: v = 32'd536870912;
			1: v = 32'd316933406;
			2: v = 32'd167458907;
			3: v = 32'd85004756;
			4: v = 32'd42667331;
			5: v = 32'd21354465;
			6: v = 32'd10679838;
			7: v = 32'd5340245;
			8: v = 32'd2670163;
			9: v = 32'd1335087;
			10: v = 32'd667544;
			11: v = 32'd333772;
			12: v = 32'd166886;
			13: v = 32'd83443;
			14: v = 32'd41722;
			15: v = 32'd20861;
			16: v = 32'd10430;
			17: v = 32'd5215;
			18: v = 32'd2608;
			19: v = 32'd1304;
			20: v = 32'd652;
			21: v = 32'd326;
			22: v = 32'd163;
			23: v = 32'd81;
			24: v = 32'd41;
			25: v = 32'd20;
			26: v = 32'd10;
			27: v = 32'd5;
			28: v = 32'd3;
			29: v = 32'd1;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

	function automatic mat_t identity_mat(int frac);
		mat_t m;
		m = '0;
		m[0] = 32'd1 << frac;
		m[4] = 32'd1 << frac;
		m[8] = 32'd1 << frac;
		return m;
	endfunction

endpackage

// ===== rtl/prrm_cordic.sv =====
module prrm_cordic (
	input  logic               clk,
	input  logic               en,
	input  logic [31:0]        phase,
	output prrm_pkg::q30_t     cos_val,
	output prrm_pkg::q30_t     sin_val
);
	import prrm_pkg::*;

	q30_t x_s [0:CORDIC_STEPS];
	q30_t y_s [0:CORDIC_STEPS];
	logic signed [32:0] z_s [0:CORDIC_STEPS];
	logic [1:0] quad_s [0:CORDIC_STEPS];
	q30_t cos_s;
	q30_t sin_s;
	logic [1:0] quad;
	logic [31:0] resid;

	always_comb begin
		quad = 2'((phase + 32'h2000_0000) >> 30);
		resid = phase - {quad, 30'd0};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= CORDIC_GAIN;
			y_s[0] <= '0;
			z_s[0] <= {resid[31], resid};
			quad_s[0] <= quad;
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		localparam logic signed [32:0] ATAN = 33'(atan_phase(i));
		always_ff @(posedge clk) begin
			if (en) begin
				if (z_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - ATAN;
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + ATAN;
				end
				quad_s[i+1] <= quad_s[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			unique case (quad_s[CORDIC_STEPS])
				2'd0: begin
					cos_s <= x_s[CORDIC_STEPS];
					sin_s <= y_s[CORDIC_STEPS];
				end
				2'd1: begin
					cos_s <= -y_s[CORDIC_STEPS];
					sin_s <= x_s[CORDIC_STEPS];
				end
				2'd2: begin
					cos_s <= -x_s[CORDIC_STEPS];
					sin_s <= -y_s[CORDIC_STEPS];
				end
				default: begin
					cos_s <= y_s[CORDIC_STEPS];
					sin_s <= -x_s[CORDIC_STEPS];
				end
			endcase
		end
	end

	assign cos_val = cos_s;
	assign sin_val = sin_s;

endmodule

// ===== rtl/prrm_euler.sv =====
module prrm_euler #(
	parameter int IN_FRAC_BITS = prrm_pkg::IN_FRAC_DEF,
	parameter int OUT_FRAC_BITS = prrm_pkg::OUT_FRAC_DEF
) (
	input  logic               clk,
	input  logic               en,
	input  logic [2:0]         fmt,
	input  logic signed [31:0] rot_a,
	input  logic signed [31:0] rot_b,
	input  logic signed [31:0] rot_c,
	output prrm_pkg::mat_t     mat
);
	import prrm_pkg::*;

	localparam int RAD_SH = IN_FRAC_BITS + RAD_PHASE_SHIFT;
	localparam int DEG_SH = IN_FRAC_BITS + DEG_PHASE_SHIFT;
	localparam int RSH = 30 - OUT_FRAC_BITS;
	localparam logic signed [34:0] HALF = (RSH > 0) ? (35'sd1 <<< (RSH - 1)) : 35'sd0;
	localparam logic signed [34:0] ONE = 35'sd1 <<< OUT_FRAC_BITS;

	function automatic logic [31:0] phase_of(logic signed [31:0] a, logic deg);
		logic [31:0] m;
		logic signed [64:0] prod;
		m = deg ? DEG_PHASE_MUL : RAD_PHASE_MUL;
		prod = $signed(a) * $signed({1'b0, m});
		return deg ? prod[DEG_SH+31:DEG_SH] : prod[RAD_SH+31:RAD_SH];
	endfunction

	function automatic q30_t mul30(q30_t a, q30_t b);
		logic signed [67:0] p;
		p = a * b;
		p = p + 68'sd536870912;
		return q30_t'(p >>> 30);
	endfunction

	function automatic logic [31:0] to_out(logic signed [34:0] v);
		logic signed [34:0] r;
		r = (v + HALF) >>> RSH;
		if (r > ONE) begin
			r = ONE;
		end
		if (r < -ONE) begin
			r = -ONE;
		end
		return r[31:0];
	endfunction

	logic deg;
	logic ypr;
	logic [31:0] ph_roll_s1, ph_pitch_s1, ph_yaw_s1;
	q30_t cr, sr, cp, sp, cy, sy;

	q30_t spsr_s34, spcr_s34, cycp_s34, sycr_s34, sysr_s34, cycr_s34;
	q30_t cysr_s34, sycp_s34, cpsr_s34, cpcr_s34, sp_s34, cy_s34, sy_s34;
	q30_t cyspsr_s35, syspsr_s35, cyspcr_s35, syspcr_s35;
	q30_t cycp_s35, sycr_s35, sysr_s35, cycr_s35, cysr_s35, sycp_s35, cpsr_s35, cpcr_s35;
	q30_t sp_s35;
	logic signed [34:0] sum_s36 [0:8];
	mat_t mat_s37;

	always_comb begin
		deg = (fmt == FMT_RPY_DEG) || (fmt == FMT_YPR_DEG);
		ypr = (fmt == FMT_YPR_RAD) || (fmt == FMT_YPR_DEG);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ph_roll_s1 <= phase_of(ypr ? rot_c : rot_a, deg);
			ph_pitch_s1 <= phase_of(rot_b, deg);
			ph_yaw_s1 <= phase_of(ypr ? rot_a : rot_c, deg);
		end
	end

	prrm_cordic u_roll (
		.clk(clk), .en(en), .phase(ph_roll_s1), .cos_val(cr), .sin_val(sr)
	);
	prrm_cordic u_pitch (
		.clk(clk), .en(en), .phase(ph_pitch_s1), .cos_val(cp), .sin_val(sp)
	);
	prrm_cordic u_yaw (
		.clk(clk), .en(en), .phase(ph_yaw_s1), .cos_val(cy), .sin_val(sy)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			spsr_s34 <= mul30(sp, sr);
			spcr_s34 <= mul30(sp, cr);
			cycp_s34 <= mul30(cy, cp);
			sycr_s34 <= mul30(sy, cr);
			sysr_s34 <= mul30(sy, sr);
			cycr_s34 <= mul30(cy, cr);
			cysr_s34 <= mul30(cy, sr);
			sycp_s34 <= mul30(sy, cp);
			cpsr_s34 <= mul30(cp, sr);
			cpcr_s34 <= mul30(cp, cr);
			sp_s34 <= sp;
			cy_s34 <= cy;
			sy_s34 <= sy;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cyspsr_s35 <= mul30(cy_s34, spsr_s34);
			syspsr_s35 <= mul30(sy_s34, spsr_s34);
			cyspcr_s35 <= mul30(cy_s34, spcr_s34);
			syspcr_s35 <= mul30(sy_s34, spcr_s34);
			cycp_s35 <= cycp_s34;
			sycr_s35 <= sycr_s34;
			sysr_s35 <= sysr_s34;
			cycr_s35 <= cycr_s34;
			cysr_s35 <= cysr_s34;
			sycp_s35 <= sycp_s34;
			cpsr_s35 <= cpsr_s34;
			cpcr_s35 <= cpcr_s34;
			sp_s35 <= sp_s34;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s36[0] <= 35'(cycp_s35);
			sum_s36[1] <= 35'(cyspsr_s35) - 35'(sycr_s35);
			sum_s36[2] <= 35'(cyspcr_s35) + 35'(sysr_s35);
			sum_s36[3] <= 35'(sycp_s35);
			sum_s36[4] <= 35'(syspsr_s35) + 35'(cycr_s35);
			sum_s36[5] <= 35'(syspcr_s35) - 35'(cysr_s35);
			sum_s36[6] <= -35'(sp_s35);
			sum_s36[7] <= 35'(cpsr_s35);
			sum_s36[8] <= 35'(cpcr_s35);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 9; j++) begin
				mat_s37[j] <= to_out(sum_s36[j]);
			end
		end
	end

	assign mat = mat_s37;

endmodule

// ===== rtl/prrm_quat.sv =====
module prrm_quat #(
	parameter int OUT_FRAC_BITS = prrm_pkg::OUT_FRAC_DEF,
	parameter int LAT = prrm_pkg::CORDIC_STEPS + 7
) (
	input  logic               clk,
	input  logic               en,
	input  logic [2:0]         fmt,
	input  logic signed [31:0] rot_a,
	input  logic signed [31:0] rot_b,
	input  logic signed [31:0] rot_c,
	input  logic signed [31:0] rot_d,
	output prrm_pkg::mat_t     mat,
	output logic               zero_err
);
	import prrm_pkg::*;

	localparam int DSTEPS = OUT_FRAC_BITS + 2;
	localparam int PAD = LAT - (OUT_FRAC_BITS + 7);

	function automatic logic signed [31:0] div4(logic signed [31:0] v);
		return (v + (v[31] ? 32'sd3 : 32'sd0)) >>> 2;
	endfunction

	function automatic logic is_big(logic signed [31:0] v);
		return (v >= 32'sh4000_0000) || (v <= -32'sh4000_0000);
	endfunction

	logic signed [31:0] qx, qy, qz, qw;
	logic big;
	logic signed [31:0] x_s1, y_s1, z_s1, w_s1;
	logic zero_s1, zero_s2, zero_s3;
	logic signed [63:0] xx_s2, yy_s2, zz_s2, ww_s2, xy_s2, zw_s2, xz_s2, yw_s2, yz_s2, xw_s2;
	logic signed [63:0] num_s3 [0:8];
	logic [63:0] n2_s3;

	logic [63:0] r_d [0:DSTEPS][0:8];
	logic [DSTEPS-1:0] q_d [0:DSTEPS][0:8];
	logic [63:0] den_d [0:DSTEPS];
	logic [8:0] neg_d [0:DSTEPS];
	logic zero_d [0:DSTEPS];

	mat_t mat_r;
	logic zero_r;

	always_comb begin
		if (fmt == FMT_QUAT_WXYZ) begin
			qx = rot_b;
			qy = rot_c;
			qz = rot_d;
			qw = rot_a;
		end else begin
			qx = rot_a;
			qy = rot_b;
			qz = rot_c;
			qw = rot_d;
		end
		big = is_big(qx) || is_big(qy) || is_big(qz) || is_big(qw);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= big ? div4(qx) : qx;
			y_s1 <= big ? div4(qy) : qy;
			z_s1 <= big ? div4(qz) : qz;
			w_s1 <= big ? div4(qw) : qw;
			zero_s1 <= (qx == 0) && (qy == 0) && (qz == 0) && (qw == 0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s2 <= x_s1 * x_s1;
			yy_s2 <= y_s1 * y_s1;
			zz_s2 <= z_s1 * z_s1;
			ww_s2 <= w_s1 * w_s1;
			xy_s2 <= x_s1 * y_s1;
			zw_s2 <= z_s1 * w_s1;
			xz_s2 <= x_s1 * z_s1;
			yw_s2 <= y_s1 * w_s1;
			yz_s2 <= y_s1 * z_s1;
			xw_s2 <= x_s1 * w_s1;
			zero_s2 <= zero_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s3[0] <= ww_s2 + xx_s2 - yy_s2 - zz_s2;
			num_s3[1] <= (xy_s2 - zw_s2) <<< 1;
			num_s3[2] <= (xz_s2 + yw_s2) <<< 1;
			num_s3[3] <= (xy_s2 + zw_s2) <<< 1;
			num_s3[4] <= ww_s2 - xx_s2 + yy_s2 - zz_s2;
			num_s3[5] <= (yz_s2 - xw_s2) <<< 1;
			num_s3[6] <= (xz_s2 - yw_s2) <<< 1;
			num_s3[7] <= (yz_s2 + xw_s2) <<< 1;
			num_s3[8] <= ww_s2 - xx_s2 - yy_s2 + zz_s2;
			n2_s3 <= xx_s2 + yy_s2 + zz_s2 + ww_s2;
			zero_s3 <= zero_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 9; j++) begin
				r_d[0][j] <= num_s3[j][63] ? 64'(-num_s3[j]) : 64'(num_s3[j]);
				q_d[0][j] <= '0;
				neg_d[0][j] <= num_s3[j][63];
			end
			den_d[0] <= n2_s3;
			zero_d[0] <= zero_s3;
		end
	end

	for (genvar k = 0; k < DSTEPS; k++) begin : g_div
		logic [63:0] sh [0:8];
		logic [63:0] nr [0:8];
		logic [DSTEPS-1:0] nq [0:8];

		always_comb begin
			for (int j = 0; j < 9; j++) begin
				sh[j] = (k == 0) ? r_d[k][j] : (r_d[k][j] << 1);
				if (sh[j] >= den_d[k]) begin
					nr[j] = sh[j] - den_d[k];
					nq[j] = {q_d[k][j][DSTEPS-2:0], 1'b1};
				end else begin
					nr[j] = sh[j];
					nq[j] = {q_d[k][j][DSTEPS-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int j = 0; j < 9; j++) begin
					r_d[k+1][j] <= nr[j];
					q_d[k+1][j] <= nq[j];
				end
				den_d[k+1] <= den_d[k];
				neg_d[k+1] <= neg_d[k];
				zero_d[k+1] <= zero_d[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_d[DSTEPS]) begin
				mat_r <= identity_mat(OUT_FRAC_BITS);
			end else begin
				for (int j = 0; j < 9; j++) begin
					mat_r[j] <= neg_d[DSTEPS][j]
						? -(32'(({1'b0, q_d[DSTEPS][j]} + 1'b1) >> 1))
						: 32'(({1'b0, q_d[DSTEPS][j]} + 1'b1) >> 1);
				end
			end
			zero_r <= zero_d[DSTEPS];
		end
	end

	if (PAD > 0) begin : g_pad
		mat_t pm_s [0:PAD-1];
		logic pz_s [0:PAD-1];
		always_ff @(posedge clk) begin
			if (en) begin
				pm_s[0] <= mat_r;
				pz_s[0] <= zero_r;
				for (int p = 1; p < PAD; p++) begin
					pm_s[p] <= pm_s[p-1];
					pz_s[p] <= pz_s[p-1];
				end
			end
		end
		assign mat = pm_s[PAD-1];
		assign zero_err = pz_s[PAD-1];
	end else begin : g_nopad
		assign mat = mat_r;
		assign zero_err = zero_r;
	end

endmodule

// ===== rtl/pose_row_to_rotation_matrix_unit.sv =====
// After the pipeline, a pose gives its rows one row per cycle while row_stall is low.
// Row 2 follows row 1, which follows row 0; a stalled row is held on the outputs.
// The pipeline stalls only when a pose at its end finds the single output register still busy.
// The rotation pipeline is 37 stages deep and advances as one whole under stall.
// Reset is asynchronous and active low; it empties the pipeline and sets the format to 0.
module pose_row_to_rotation_matrix_unit #(
	parameter int IN_FRAC_BITS = prrm_pkg::IN_FRAC_DEF,
	parameter int OUT_FRAC_BITS = prrm_pkg::OUT_FRAC_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_data,
	input  logic               pose_valid,
	output logic               pose_stall,
	input  logic [15:0]        sample_index,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] rot_a,
	input  logic signed [31:0] rot_b,
	input  logic signed [31:0] rot_c,
	input  logic signed [31:0] rot_d,
	output logic               row_valid,
	input  logic               row_stall,
	output logic [15:0]        out_sample_index,
	output logic [1:0]         row_number,
	output logic signed [31:0] elem_col0,
	output logic signed [31:0] elem_col1,
	output logic signed [31:0] elem_col2,
	output logic signed [31:0] trans_elem,
	output logic               zero_quat_error,
	output logic               last_row
);
	import prrm_pkg::*;

	localparam int LAT = CORDIC_STEPS + 7;

	logic [2:0] fmt_q;
	logic adv;
	logic vld_s [0:LAT-1];
	logic [15:0] idx_s [0:LAT-1];
	logic [31:0] px_s [0:LAT-1];
	logic [31:0] py_s [0:LAT-1];
	logic [31:0] pz_s [0:LAT-1];
	logic [2:0] fmt_s [0:LAT-1];

	mat_t quat_mat, eul_mat, sel_mat;
	logic quat_err, sel_err;

	logic ov_q;
	logic [1:0] row_q;
	mat_t mat_q;
	logic err_q;
	logic [15:0] idx_q;
	logic [31:0] px_q, py_q, pz_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_QUAT_XYZW;
		end else if (cfg_valid && cfg_ready) begin
			fmt_q <= cfg_data;
		end
	end

	assign adv = !vld_s[LAT-1] || !ov_q || (!row_stall && row_q == ROW_LAST);
	assign pose_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAT; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[0] <= pose_valid;
			for (int k = 1; k < LAT; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s[0] <= sample_index;
			px_s[0] <= pos_x;
			py_s[0] <= pos_y;
			pz_s[0] <= pos_z;
			fmt_s[0] <= fmt_q;
			for (int k = 1; k < LAT; k++) begin
				idx_s[k] <= idx_s[k-1];
				px_s[k] <= px_s[k-1];
				py_s[k] <= py_s[k-1];
				pz_s[k] <= pz_s[k-1];
				fmt_s[k] <= fmt_s[k-1];
			end
		end
	end

	prrm_quat #(
		.OUT_FRAC_BITS(OUT_FRAC_BITS),
		.LAT(LAT)
	) u_quat (
		.clk(clk), .en(adv), .fmt(fmt_q),
		.rot_a(rot_a), .rot_b(rot_b), .rot_c(rot_c), .rot_d(rot_d),
		.mat(quat_mat), .zero_err(quat_err)
	);

	prrm_euler #(
		.IN_FRAC_BITS(IN_FRAC_BITS),
		.OUT_FRAC_BITS(OUT_FRAC_BITS)
	) u_euler (
		.clk(clk), .en(adv), .fmt(fmt_q),
		.rot_a(rot_a), .rot_b(rot_b), .rot_c(rot_c),
		.mat(eul_mat)
	);

	always_comb begin
		sel_err = 1'b0;
		if (fmt_s[LAT-1] == FMT_QUAT_XYZW || fmt_s[LAT-1] == FMT_QUAT_WXYZ) begin
			sel_mat = quat_mat;
			sel_err = quat_err;
		end else if (fmt_s[LAT-1] == FMT_RPY_RAD || fmt_s[LAT-1] == FMT_RPY_DEG ||
			fmt_s[LAT-1] == FMT_YPR_RAD || fmt_s[LAT-1] == FMT_YPR_DEG) begin
			sel_mat = eul_mat;
		end else begin
			sel_mat = identity_mat(OUT_FRAC_BITS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			row_q <= 2'd0;
		end else if (adv && vld_s[LAT-1]) begin
			ov_q <= 1'b1;
			row_q <= 2'd0;
		end else if (ov_q && !row_stall) begin
			if (row_q == ROW_LAST) begin
				ov_q <= 1'b0;
			end else begin
				row_q <= row_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s[LAT-1]) begin
			mat_q <= sel_mat;
			err_q <= sel_err;
			idx_q <= idx_s[LAT-1];
			px_q <= px_s[LAT-1];
			py_q <= py_s[LAT-1];
			pz_q <= pz_s[LAT-1];
		end
	end

	always_comb begin
		unique case (row_q)
			2'd0: begin
				elem_col0 = mat_q[0];
				elem_col1 = mat_q[1];
				elem_col2 = mat_q[2];
				trans_elem = px_q;
			end
			2'd1: begin
				elem_col0 = mat_q[3];
				elem_col1 = mat_q[4];
				elem_col2 = mat_q[5];
				trans_elem = py_q;
			end
			default: begin
				elem_col0 = mat_q[6];
				elem_col1 = mat_q[7];
				elem_col2 = mat_q[8];
				trans_elem = pz_q;
			end
		endcase
	end

	assign row_valid = ov_q;
	assign row_number = row_q;
	assign out_sample_index = idx_q;
	assign zero_quat_error = err_q;
	assign last_row = (row_q == ROW_LAST);

endmodule

// ===== rtl/prrm_checker.sv =====
module prrm_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               row_valid,
	input logic               row_stall,
	input logic [15:0]        out_sample_index,
	input logic [1:0]         row_number,
	input logic signed [31:0] elem_col0,
	input logic signed [31:0] elem_col1,
	input logic signed [31:0] elem_col2,
	input logic signed [31:0] trans_elem,
	input logic               zero_quat_error,
	input logic               last_row
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid && row_stall |=> row_valid && $stable(row_number) && $stable(elem_col0)
			&& $stable(trans_elem))
		else $error("stalled row changed");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid |-> (last_row == (row_number == 2'd2)) && (row_number != 2'd3))
		else $error("last row mark does not match row number");

	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid && !row_stall && row_number != 2'd2 |=>
			row_valid && row_number == $past(row_number) + 2'd1
			&& $stable(out_sample_index) && $stable(zero_quat_error))
		else $error("rows of one item are not consecutive");

	a_ident: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid && zero_quat_error && row_number == 2'd0 |->
			elem_col1 == 32'sd0 && elem_col2 == 32'sd0 && elem_col0 > 32'sd0)
		else $error("zero quaternion did not give identity");

endmodule

bind pose_row_to_rotation_matrix_unit prrm_checker u_prrm_checker (.*);

// ===== bench/tb_pose_row_to_rotation_matrix_unit.sv =====
module tb_pose_row_to_rotation_matrix_unit;
	import prrm_pkg::*;

	typedef struct packed {
		logic [15:0] sidx;
		logic [1:0]  row;
		logic [31:0] c0;
		logic [31:0] c1;
		logic [31:0] c2;
		logic [31:0] tr;
		logic        zq;
		logic        lst;
	} row_item_t;

	class pose_scoreboard;
		row_item_t   rows_due[$];
		int          fails;
		int          checked;
		logic [2:0]  fmt;

		function longint q30_mul(longint a, longint b);
			return (a * b + (longint'(1) << 29)) >>> 30;
		endfunction

		function longint clamp_out(longint v);
			longint one;
			one = longint'(1) << 30;
			if (v > one) v = one;
			if (v < -one) v = -one;
			return v;
		endfunction

		function longint ratio_round(longint num, longint den);
			logic   neg;
			longint r;
			longint q;
			neg = num < 0;
			r = neg ? -num : num;
			q = 0;
			if (r >= den) begin
				r -= den;
				q = 1;
			end
			for (int i = 0; i < 31; i++) begin
				r = r << 1;
				q = q << 1;
				if (r >= den) begin
					r -= den;
					q |= 1;
				end
			end
			q = (q + 1) >> 1;
			return neg ? -q : q;
		endfunction

		function logic [31:0] to_phase(longint a, logic deg);
			logic [63:0] p;
			int          sh;
			p = 64'(a) * (deg ? 64'(DEG_PHASE_MUL) : 64'(RAD_PHASE_MUL));
			sh = 16 + (deg ? DEG_PHASE_SHIFT : RAD_PHASE_SHIFT);
			return 32'(p >> sh);
		endfunction

		function void sin_cos(logic [31:0] ph, output longint c, output longint s);
			logic [1:0]  quad;
			logic [31:0] rr;
			longint      z;
			longint      x;
			longint      y;
			longint      nx;
			quad = 2'((ph + 32'h2000_0000) >> 30);
			rr = ph - ({30'd0, quad} << 30);
			z = longint'(signed'(rr));
			x = 652032874;
			y = 0;
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				if (z >= 0) begin
					nx = x - (y >>> i);
					y = y + (x >>> i);
					z -= longint'(atan_phase(i));
				end else begin
					nx = x + (y >>> i);
					y = y - (x >>> i);
					z += longint'(atan_phase(i));
				end
				x = nx;
			end
			case (quad)
				2'd0: begin c = x; s = y; end
				2'd1: begin c = -y; s = x; end
				2'd2: begin c = -x; s = -y; end
				default: begin c = y; s = -x; end
			endcase
		endfunction

		function void unit_rows(ref longint m[9]);
			for (int i = 0; i < 9; i++) m[i] = (i % 4 == 0) ? (longint'(1) << 30) : 0;
		endfunction

		function logic quat_rows(longint x, longint y, longint z, longint w, ref longint m[9]);
			longint lim;
			longint xx, yy, zz, ww, n2;
			lim = longint'(1) << 30;
			if (x == 0 && y == 0 && z == 0 && w == 0) begin
				unit_rows(m);
				return 1'b1;
			end
			if (x >= lim || x <= -lim || y >= lim || y <= -lim ||
			    z >= lim || z <= -lim || w >= lim || w <= -lim) begin
				x = x / 4; y = y / 4; z = z / 4; w = w / 4;
			end
			xx = x * x; yy = y * y; zz = z * z; ww = w * w;
			n2 = xx + yy + zz + ww;
			if (n2 == 0) begin
				unit_rows(m);
				return 1'b1;
			end
			m[0] = ratio_round(ww + xx - yy - zz, n2);
			m[1] = ratio_round(2 * (x * y - z * w), n2);
			m[2] = ratio_round(2 * (x * z + y * w), n2);
			m[3] = ratio_round(2 * (x * y + z * w), n2);
			m[4] = ratio_round(ww - xx + yy - zz, n2);
			m[5] = ratio_round(2 * (y * z - x * w), n2);
			m[6] = ratio_round(2 * (x * z - y * w), n2);
			m[7] = ratio_round(2 * (y * z + x * w), n2);
			m[8] = ratio_round(ww - xx - yy + zz, n2);
			return 1'b0;
		endfunction

		function void euler_rows(longint ro, longint pi, longint ya, logic deg, ref longint m[9]);
			longint cr, sr, cp, sp, cy, sy;
			sin_cos(to_phase(ro, deg), cr, sr);
			sin_cos(to_phase(pi, deg), cp, sp);
			sin_cos(to_phase(ya, deg), cy, sy);
			m[0] = q30_mul(cy, cp);
			m[1] = q30_mul(cy, q30_mul(sp, sr)) - q30_mul(sy, cr);
			m[2] = q30_mul(cy, q30_mul(sp, cr)) + q30_mul(sy, sr);
			m[3] = q30_mul(sy, cp);
			m[4] = q30_mul(sy, q30_mul(sp, sr)) + q30_mul(cy, cr);
			m[5] = q30_mul(sy, q30_mul(sp, cr)) - q30_mul(cy, sr);
			m[6] = -sp;
			m[7] = q30_mul(cp, sr);
			m[8] = q30_mul(cp, cr);
			for (int i = 0; i < 9; i++) m[i] = clamp_out(m[i]);
		endfunction

		function void note_pose(logic [15:0] sidx, logic [31:0] px, logic [31:0] py,
				logic [31:0] pz, logic [31:0] ra, logic [31:0] rb, logic [31:0] rc,
				logic [31:0] rd);
			longint    m[9];
			longint    a, b, c, d;
			logic      zq;
			row_item_t it;
			a = longint'(signed'(ra)); b = longint'(signed'(rb));
			c = longint'(signed'(rc)); d = longint'(signed'(rd));
			zq = 1'b0;
			case (fmt)
				FMT_QUAT_XYZW: zq = quat_rows(a, b, c, d, m);
				FMT_QUAT_WXYZ: zq = quat_rows(b, c, d, a, m);
				FMT_RPY_RAD: euler_rows(a, b, c, 1'b0, m);
				FMT_RPY_DEG: euler_rows(a, b, c, 1'b1, m);
				FMT_YPR_RAD: euler_rows(c, b, a, 1'b0, m);
				FMT_YPR_DEG: euler_rows(c, b, a, 1'b1, m);
				default: unit_rows(m);
			endcase
			for (int r = 0; r < 3; r++) begin
				it.sidx = sidx;
				it.row = 2'(r);
				it.c0 = 32'(m[3 * r]);
				it.c1 = 32'(m[3 * r + 1]);
				it.c2 = 32'(m[3 * r + 2]);
				it.tr = (r == 0) ? px : (r == 1) ? py : pz;
				it.zq = zq;
				it.lst = (2'(r) == ROW_LAST);
				rows_due.insert(rows_due.size(), it);
			end
		endfunction

		function void check_row(row_item_t got);
			row_item_t e;
			checked++;
			if (rows_due.size() == 0) begin
				$display("%0t: unexpected row, sample %h row %0d", $time, got.sidx, got.row);
				fails++;
				return;
			end
			e = rows_due.pop_front();
			if (got !== e) begin
				fails++;
				$display("%0t: mismatch expected idx %h row %0d %h %h %h tr %h zq %b last %b",
					$time, e.sidx, e.row, e.c0, e.c1, e.c2, e.tr, e.zq, e.lst);
				$display("%0t:          actual   idx %h row %0d %h %h %h tr %h zq %b last %b",
					$time, got.sidx, got.row, got.c0, got.c1, got.c2, got.tr, got.zq, got.lst);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [2:0] cfg_data = '0;
	logic pose_valid = 0;
	logic pose_stall;
	logic [15:0] sample_index = '0;
	logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic signed [31:0] rot_a = '0, rot_b = '0, rot_c = '0, rot_d = '0;
	logic row_valid;
	logic row_stall = 0;
	logic [15:0] out_sample_index;
	logic [1:0] row_number;
	logic signed [31:0] elem_col0, elem_col1, elem_col2, trans_elem;
	logic zero_quat_error, last_row;

	pose_row_to_rotation_matrix_unit dut (.*);

	always #1 clk = ~clk;

	pose_scoreboard board = new();
	int long_hold = 0;
	int poses_sent = 0;

	function int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 45) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	always @(posedge clk) begin
		row_item_t got;
		if (arst_n && row_valid && !row_stall) begin
			got.sidx = out_sample_index; got.row = row_number;
			got.c0 = elem_col0; got.c1 = elem_col1; got.c2 = elem_col2;
			got.tr = trans_elem; got.zq = zero_quat_error; got.lst = last_row;
			board.check_row(got);
		end
	end

	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold > 0) begin
				row_stall <= 1'b1;
				long_hold--;
			end else if (row_stall) begin
				row_stall <= 1'b0;
			end else begin
				g = gap_len();
				if (g > 0 && $urandom_range(0, 3) != 0) begin
					row_stall <= 1'b1;
					repeat (g) @(negedge clk);
					row_stall <= 1'b0;
				end
			end
		end
	end

	task automatic send_pose(logic [31:0] ra, logic [31:0] rb, logic [31:0] rc,
			logic [31:0] rd);
		int g;
		sample_index <= 16'($urandom);
		pos_x <= $urandom; pos_y <= $urandom; pos_z <= $urandom;
		rot_a <= ra; rot_b <= rb; rot_c <= rc; rot_d <= rd;
		pose_valid <= 1'b1;
		do @(posedge clk); while (pose_stall);
		board.note_pose(sample_index, pos_x, pos_y, pos_z, rot_a, rot_b, rot_c, rot_d);
		poses_sent++;
		@(negedge clk);
		g = gap_len();
		if (g > 0 && $urandom_range(0, 2) == 0) begin
			pose_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
	endtask

	task automatic drain();
		pose_valid <= 1'b0;
		while (board.rows_due.size() != 0) @(negedge clk);
		repeat (5) @(negedge clk);
	endtask

	task automatic write_format(logic [2:0] f);
		drain();
		cfg_data <= f;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		board.fmt = f;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function logic [31:0] rand_rot(logic [2:0] f);
		int p;
		p = $urandom_range(0, 9);
		if (p == 0) return 32'h8000_0000;
		if (p == 1) return 32'h7fff_ffff;
		if (p == 2) return 32'd0;
		if (f <= FMT_QUAT_WXYZ && p < 6) return 32'(signed'($urandom_range(0, 131072)) - 65536);
		if (f > FMT_QUAT_WXYZ && p < 7) return 32'(signed'($urandom_range(0, 1474560)) - 737280);
		return $urandom;
	endfunction

	initial begin
		logic [2:0] fmts[8];
		logic [2:0] f;
		fmts = '{FMT_QUAT_XYZW, FMT_QUAT_WXYZ, FMT_RPY_RAD, FMT_RPY_DEG,
			FMT_YPR_RAD, FMT_YPR_DEG, 3'd6, 3'd7};
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		board.fmt = FMT_QUAT_XYZW;
		send_pose(0, 0, 0, 0);
		send_pose(0, 0, 0, 32'h0001_0000);
		send_pose(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
		send_pose(32'h4000_0000, 1, 0, 0);
		send_pose(0, 0, 0, 1);
		send_pose(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		write_format(FMT_QUAT_WXYZ);
		send_pose(0, 0, 0, 0);
		send_pose(32'h0000_b505, 32'h0000_b505, 0, 0);
		for (int k = 2; k < 8; k++) begin
			write_format(fmts[k]);
			send_pose(0, 0, 0, 0);
			send_pose(32'h7fff_ffff, 32'h8000_0000, 32'h0019_2200, 32'hffff_ffff);
			send_pose(32'h005a_0000, 32'hffa6_0000, 32'h00b4_0000, 0);
		end
		for (int k = 0; k < 16; k++) begin
			f = (k < 8) ? fmts[k] : 3'($urandom_range(0, 5));
			write_format(f);
			if (k == 3) long_hold = 200;
			repeat (32) send_pose(rand_rot(f), rand_rot(f), rand_rot(f), rand_rot(f));
			if (k == 5) drain();
		end
		write_format(FMT_QUAT_XYZW);
		repeat (8) send_pose(rand_rot(0), rand_rot(0), rand_rot(0), rand_rot(0));
		drain();
		repeat (60) @(negedge clk);
		$display("Sent %0d poses over all six formats and the unused codes; checked %0d rows.",
			poses_sent, board.checked);
		if (board.fails == 0 && board.rows_due.size() == 0)
			$display("[pose_row_to_rotation_matrix_unit] OK");
		else
			$display("[pose_row_to_rotation_matrix_unit] ERROR");
		$finish;
	end

	initial begin
		#400000;
		$display("[pose_row_to_rotation_matrix_unit] ERROR");
		$finish;
	end
endmodule

// ===== files.f =====
rtl/prrm_pkg.sv
rtl/prrm_cordic.sv
rtl/prrm_euler.sv
rtl/prrm_quat.sv
rtl/pose_row_to_rotation_matrix_unit.sv
rtl/prrm_checker.sv
bench/tb_pose_row_to_rotation_matrix_unit.sv
